// ===== rtl/sprite_pixel_collision_macros.svh =====
// Assertion macros shared by the checker files of sprite_pixel_collision.
// No dependencies; the using scope must provide aclk and aresetn.
`ifndef SPRITE_PIXEL_COLLISION_MACROS_SVH
`define SPRITE_PIXEL_COLLISION_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define SPC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sprite_pixel_collision check failed");

// Next-cycle implication, gated off during reset.
`define SPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sprite_pixel_collision check failed");

`endif

// ===== rtl/spc_pkg.sv =====
// Package for sprite_pixel_collision: field widths, defaults, op codes, helpers.
// No dependencies.
package spc_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;
    localparam int POS_W          = 12;
    localparam int SIZE_W         = 6;
    localparam int QDEPTH         = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    // index width for n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/spc_queue.sv =====
// Small command queue between the front (classify) and back (mask) stages.
// Depends on spc_pkg.
module spc_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    import spc_pkg::*;

    localparam int PW = idx_w(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    logic [DATA_W-1:0] mem_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;

    assign full     = (count_reg == NW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/spc_front.sv =====
// Front stage: clamps sizes, walks the pixel counters, latches the first
// sprite's geometry and turns each beat into a mask command. Depends on spc_pkg.
module spc_front #(
    parameter int MAX_WIDTH  = spc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = spc_pkg::MAX_HEIGHT_DEF,
    parameter int CMD_W      = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_fire,
    input  logic                             in_op,
    input  logic signed [spc_pkg::POS_W-1:0] in_pos_x,
    input  logic signed [spc_pkg::POS_W-1:0] in_pos_y,
    input  logic [spc_pkg::SIZE_W-1:0]       in_width,
    input  logic [spc_pkg::SIZE_W-1:0]       in_height,
    input  logic                             in_opaque,
    input  logic                             in_last,
    output logic [CMD_W-1:0]                 cmd
);
    import spc_pkg::*;

    localparam int CW    = idx_w(MAX_WIDTH);
    localparam int RW    = idx_w(MAX_HEIGHT);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
    localparam int ZW    = SIZE_W + 1;
    localparam int LW    = POS_W + 2;

    typedef struct packed {
        op_t           op;
        logic          clear;
        logic          last;
        logic          px_bit;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } cmd_t;

    logic [CW-1:0]           col_reg, col_next;
    logic [RW-1:0]           row_reg, row_next;
    logic signed [POS_W-1:0] first_pos_x_reg, first_pos_y_reg;
    logic [WSZ_W-1:0]        first_width_reg;
    logic [HSZ_W-1:0]        first_height_reg;

    logic [ZW-1:0]     w_ext, h_ext, w_cl, h_cl, col_inc, row_inc;
    logic signed [LW-1:0] lx, ly;
    logic [LW-1:0]     lx_u, ly_u;
    logic              in_x, in_y;
    op_t               op;
    cmd_t              cmd_s;

    // size clamp to 1..MAX
    assign w_ext = {1'b0, in_width};
    assign h_ext = {1'b0, in_height};
    assign w_cl  = (w_ext == '0) ? ZW'(1) : (w_ext > ZW'(MAX_WIDTH))  ? ZW'(MAX_WIDTH)  : w_ext;
    assign h_cl  = (h_ext == '0) ? ZW'(1) : (h_ext > ZW'(MAX_HEIGHT)) ? ZW'(MAX_HEIGHT) : h_ext;

    assign op = op_t'(in_op);

    // second-sprite pixel in the first sprite's frame
    assign lx   = LW'(in_pos_x) + $signed(LW'(col_reg)) - LW'(first_pos_x_reg);
    assign ly   = LW'(in_pos_y) + $signed(LW'(row_reg)) - LW'(first_pos_y_reg);
    assign lx_u = lx;
    assign ly_u = ly;
    assign in_x = !lx[LW-1] && (lx_u < LW'(first_width_reg));
    assign in_y = !ly[LW-1] && (ly_u < LW'(first_height_reg));

    always_comb begin
        cmd_s.op    = op;
        cmd_s.clear = (op == OP_LOAD) && (col_reg == '0) && (row_reg == '0);
        cmd_s.last  = in_last;
        if (op == OP_LOAD) begin
            cmd_s.px_bit = in_opaque;
            cmd_s.row    = row_reg;
            cmd_s.col    = col_reg;
        end else begin
            cmd_s.px_bit = in_opaque && in_x && in_y;
            cmd_s.row    = ly_u[RW-1:0];
            cmd_s.col    = lx_u[CW-1:0];
        end
    end

    assign cmd = cmd_s;

    // raster counters
    assign col_inc = ZW'(col_reg) + ZW'(1);
    assign row_inc = ZW'(row_reg) + ZW'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_last) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= w_cl) begin
            col_next = '0;
            row_next = (row_inc >= h_cl) ? '0 : row_inc[RW-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg          <= '0;
            row_reg          <= '0;
            first_pos_x_reg  <= '0;
            first_pos_y_reg  <= '0;
            first_width_reg  <= '0;
            first_height_reg <= '0;
        end else if (in_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (op == OP_LOAD) begin
                first_pos_x_reg  <= in_pos_x;
                first_pos_y_reg  <= in_pos_y;
                first_width_reg  <= w_cl[WSZ_W-1:0];
                first_height_reg <= h_cl[HSZ_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/spc_back.sv =====
// Back stage: holds the first sprite's mask, runs load and test commands,
// accumulates the hit flag and registers the collision beat. Depends on spc_pkg.
module spc_back #(
    parameter int MAX_WIDTH  = spc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = spc_pkg::MAX_HEIGHT_DEF,
    parameter int CMD_W      = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CMD_W-1:0] cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_collision
);
    import spc_pkg::*;

    localparam int CW = idx_w(MAX_WIDTH);
    localparam int RW = idx_w(MAX_HEIGHT);

    typedef struct packed {
        op_t           op;
        logic          clear;
        logic          last;
        logic          px_bit;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } cmd_t;

    logic [MAX_WIDTH-1:0]  mask_reg [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] live_reg, live_next;
    logic                  hit_seen_reg, hit_seen_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_collision_reg, m_collision_next;

    cmd_t                  c;
    logic                  emits, is_load, hit;
    logic [MAX_WIDTH-1:0]  row_fresh;

    assign c       = cmd;
    assign is_load = (c.op == OP_LOAD);
    assign emits   = (c.op == OP_TEST) && c.last;
    // a result beat may only leave once the output register is free
    assign cmd_pop = !cmd_empty && (!emits || !m_valid_reg || m_ready);

    // rows not written since the last load start read as clear
    assign hit       = c.px_bit && live_reg[c.row] && mask_reg[c.row][c.col];
    assign row_fresh = MAX_WIDTH'(c.px_bit) << c.col;

    always_comb begin
        live_next        = live_reg;
        hit_seen_next    = hit_seen_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_collision_next = m_collision_reg;
        if (cmd_pop) begin
            if (is_load) begin
                if (c.clear) begin
                    live_next = '0;
                end
                live_next[c.row] = 1'b1;
            end else if (c.last) begin
                m_valid_next     = 1'b1;
                m_collision_next = hit_seen_reg || hit;
                hit_seen_next    = 1'b0;
            end else begin
                hit_seen_next = hit_seen_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg     <= '0;
            hit_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            live_reg     <= live_next;
            hit_seen_reg <= hit_seen_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_collision_reg <= m_collision_next;
        if (cmd_pop && is_load) begin
            if (c.clear || !live_reg[c.row]) begin
                mask_reg[c.row] <= row_fresh;
            end else begin
                mask_reg[c.row][c.col] <= c.px_bit;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_collision = m_collision_reg;

endmodule

// ===== rtl/sprite_pixel_collision.sv =====
// sprite_pixel_collision: an accepted beat is written into the command queue, and the back stage registers
// its mask update or collision beat when it pops that command; throughput one pixel per cycle while no result
// stall holds the queue, set by the single mask access per cycle in the back stage.
// Backpressure on m_ready stalls only the last test pixel; up to 3 beats in flight.
// Reset (aresetn low, synchronous) clears counters, latched geometry, hit flag,
// queue and row marks; mask bits are not cleared, a load start clears all row marks.
module sprite_pixel_collision #(
    parameter int MAX_WIDTH  = spc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = spc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic signed [spc_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [spc_pkg::POS_W-1:0] s_pos_y,
    input  logic [spc_pkg::SIZE_W-1:0]       s_width,
    input  logic [spc_pkg::SIZE_W-1:0]       s_height,
    input  logic                             s_opaque,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_collision
);
    import spc_pkg::*;

    // command: op, clear, last, pixel bit, row, column
    localparam int CW    = idx_w(MAX_WIDTH);
    localparam int RW    = idx_w(MAX_HEIGHT);
    localparam int CMD_W = 4 + RW + CW;

    logic             in_fire;
    logic [CMD_W-1:0] front_cmd, back_cmd;
    logic             q_full, q_empty, q_pop;

    // a beat is taken whenever the queue has a slot
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    spc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_op     (s_op),
        .in_pos_x  (s_pos_x),
        .in_pos_y  (s_pos_y),
        .in_width  (s_width),
        .in_height (s_height),
        .in_opaque (s_opaque),
        .in_last   (s_last),
        .cmd       (front_cmd)
    );

    // decouples classification from mask access
    spc_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_cmd),
        .empty     (q_empty)
    );

    spc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (back_cmd),
        .cmd_empty   (q_empty),
        .cmd_pop     (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_collision (m_collision)
    );

endmodule

// ===== rtl/spc_checker.sv =====
// Port-level checker for sprite_pixel_collision, bound to the top level.
// Depends on spc_pkg and sprite_pixel_collision_macros.svh.
`include "sprite_pixel_collision_macros.svh"

module spc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_op,
    input logic signed [spc_pkg::POS_W-1:0] s_pos_x,
    input logic signed [spc_pkg::POS_W-1:0] s_pos_y,
    input logic [spc_pkg::SIZE_W-1:0]       s_width,
    input logic [spc_pkg::SIZE_W-1:0]       s_height,
    input logic                             s_opaque,
    input logic                             s_last,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_collision
);
    import spc_pkg::*;

    // result beats owed: last test pixels taken minus collision beats delivered
    logic [2:0] owed_reg, owed_next;
    logic       owe_inc, owe_dec;

    assign owe_inc = s_valid && s_ready && (op_t'(s_op) == OP_TEST) && s_last;
    assign owe_dec = m_valid && m_ready;

    always_comb begin
        owed_next = owed_reg;
        if (owe_inc && !owe_dec) begin
            owed_next = owed_reg + 3'd1;
        end else if (owe_dec && !owe_inc) begin
            owed_next = owed_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= '0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    `SPC_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_collision))
    `SPC_ASSERT_IMPL(a_no_spurious, m_valid, owed_reg != 3'd0)
    `SPC_ASSERT_IMPL(a_bounded, 1'b1, owed_reg <= 3'd3)

endmodule

bind sprite_pixel_collision spc_checker u_spc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .s_pos_x     (s_pos_x),
    .s_pos_y     (s_pos_y),
    .s_width     (s_width),
    .s_height    (s_height),
    .s_opaque    (s_opaque),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_collision (m_collision)
);

// ===== verif/sprite_pixel_collision_checker.sv =====
// Scoreboard for sprite_pixel_collision: follows accepted pixel beats, predicts each
// collision beat and compares results in order. Depends on spc_pkg.
module sprite_pixel_collision_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_op,
    input  logic signed [spc_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [spc_pkg::POS_W-1:0] s_pos_y,
    input  logic [spc_pkg::SIZE_W-1:0]       s_width,
    input  logic [spc_pkg::SIZE_W-1:0]       s_height,
    input  logic                             s_opaque,
    input  logic                             s_last,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_collision,
    output int                               fail_count,
    output int                               results_due,
    output int                               results_seen,
    output int                               hits_seen
);
    localparam int MAXW = spc_pkg::MAX_WIDTH_DEF;
    localparam int MAXH = spc_pkg::MAX_HEIGHT_DEF;

    // first sprite as the block should hold it
    logic [MAXW-1:0]                  sprite_mask [MAXH];
    logic signed [spc_pkg::POS_W-1:0] anchor_x;
    logic signed [spc_pkg::POS_W-1:0] anchor_y;
    int unsigned                      anchor_w;
    int unsigned                      anchor_h;
    int unsigned                      scan_col;
    int unsigned                      scan_row;
    bit                               overlap_seen;
    bit                               collision_due [$];
    bit                               want;

    function automatic int unsigned fit_size(input logic [spc_pkg::SIZE_W-1:0] raw,
                                             input int unsigned maxv);
        if (raw == 0) return 1;
        if (raw > maxv) return maxv;
        return raw;
    endfunction

    task automatic flag_mismatch(input string what, input logic exp_bit, input logic got_bit);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s at result %0d: expected collision=%0b, got %0b",
                     what, results_seen, exp_bit, got_bit);
    endtask

    // apply one accepted pixel beat to the predicted state
    task automatic follow_pixel();
        int unsigned w, h, col, row;
        int lx, ly;
        w   = fit_size(s_width, MAXW);
        h   = fit_size(s_height, MAXH);
        col = scan_col;
        row = scan_row;
        if (s_op == spc_pkg::OP_LOAD) begin
            if (col == 0 && row == 0) begin
                foreach (sprite_mask[i]) sprite_mask[i] = '0;
            end
            sprite_mask[row][col] = s_opaque;
            anchor_x = s_pos_x;
            anchor_y = s_pos_y;
            anchor_w = w;
            anchor_h = h;
        end else begin
            lx = int'(s_pos_x) + int'(col) - int'(anchor_x);
            ly = int'(s_pos_y) + int'(row) - int'(anchor_y);
            if (s_opaque && lx >= 0 && ly >= 0 && lx < int'(anchor_w) && ly < int'(anchor_h)
                && lx < MAXW && ly < MAXH && sprite_mask[ly][lx])
                overlap_seen = 1'b1;
        end
        if (s_last) begin
            if (s_op == spc_pkg::OP_TEST) begin
                collision_due.push_back(overlap_seen);
                overlap_seen = 1'b0;
            end
            scan_col = 0;
            scan_row = 0;
        end else begin
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
            scan_col = col;
            scan_row = row;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            anchor_x     = '0;
            anchor_y     = '0;
            anchor_w     = 0;
            anchor_h     = 0;
            scan_col     = 0;
            scan_row     = 0;
            overlap_seen = 1'b0;
            collision_due.delete();
        end else begin
            if (s_valid && s_ready) follow_pixel();
            if (m_valid && m_ready) begin
                if (collision_due.size() == 0) begin
                    flag_mismatch("unexpected collision beat", 1'bx, m_collision);
                end else begin
                    want = collision_due.pop_front();
                    if (m_collision !== want) flag_mismatch("collision", want, m_collision);
                end
                results_seen++;
                if (m_collision === 1'b1) hits_seen++;
            end
        end
        results_due = collision_due.size();
    end

endmodule

// ===== verif/tb_sprite_pixel_collision.sv =====
// Testbench top for sprite_pixel_collision: clock, reset, pixel stimulus, result-side
// stalls and the verdict. Depends on spc_pkg, the block and sprite_pixel_collision_checker.
module tb_sprite_pixel_collision;

    localparam int MAX_SIDE     = spc_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_BEATS = 1600;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_op;
    logic signed [spc_pkg::POS_W-1:0] s_pos_x;
    logic signed [spc_pkg::POS_W-1:0] s_pos_y;
    logic [spc_pkg::SIZE_W-1:0]       s_width;
    logic [spc_pkg::SIZE_W-1:0]       s_height;
    logic                             s_opaque;
    logic                             s_last;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_collision;

    int fail_count, results_due, results_seen, hits_seen;

    // idle rates in percent: sender gaps and receiver stalls
    int s_gap_pct;
    int m_stall_pct;

    int beats_sent;
    int sprites_sent;
    int noise_beats;

    sprite_pixel_collision u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_width     (s_width),
        .s_height    (s_height),
        .s_opaque    (s_opaque),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_collision (m_collision)
    );

    sprite_pixel_collision_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_width      (s_width),
        .s_height     (s_height),
        .s_opaque     (s_opaque),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_collision  (m_collision),
        .fail_count   (fail_count),
        .results_due  (results_due),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: ready is redrawn every falling edge at the current stall rate.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    // Hard stop; a correct run needs a few percent of this.
    initial begin
        #400000;
        $display("Timeout: run did not drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One pixel beat. Called at a falling edge, returns at a falling edge.
    // Random gaps drop valid before the beat; once valid is up it holds until accepted.
    task automatic send_pixel(input spc_pkg::op_t op,
                              input logic signed [spc_pkg::POS_W-1:0] px,
                              input logic signed [spc_pkg::POS_W-1:0] py,
                              input logic [spc_pkg::SIZE_W-1:0] w_raw,
                              input logic [spc_pkg::SIZE_W-1:0] h_raw,
                              input logic opq,
                              input logic lst);
        while ($urandom_range(99) < s_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_pos_x  <= px;
        s_pos_y  <= py;
        s_width  <= w_raw;
        s_height <= h_raw;
        s_opaque <= opq;
        s_last   <= lst;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every predicted collision beat has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
    endtask

    // Sizes of 1 and of the maximum are sometimes sent in an out-of-range encoding
    // that the block clamps back to the same size.
    function automatic logic [spc_pkg::SIZE_W-1:0] encode_size(input int n);
        if (n == 1 && $urandom_range(3) == 0) return '0;
        if (n == MAX_SIDE && $urandom_range(1) == 0)
            return spc_pkg::SIZE_W'($urandom_range(63, MAX_SIDE + 1));
        return spc_pkg::SIZE_W'(n);
    endfunction

    // Mostly tiny sprites so collision beats come often; now and then a wide or tall one.
    function automatic int pick_side();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(4, 1);
        if (roll < 97) return $urandom_range(10, 5);
        return MAX_SIDE;
    endfunction

    function automatic int pick_pos();
        int corners [4] = '{-2048, 2047, 0, -1};
        if ($urandom_range(9) == 0) return corners[$urandom_range(3)];
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // A whole well-formed sprite in row-major order, last on the final pixel.
    task automatic send_sprite(input spc_pkg::op_t op, input int px, input int py,
                               input int w, input int h, input int density);
        logic [spc_pkg::SIZE_W-1:0] w_raw, h_raw;
        w_raw = encode_size(w);
        h_raw = encode_size(h);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_pixel(op, spc_pkg::POS_W'(px), spc_pkg::POS_W'(py), w_raw, h_raw,
                           $urandom_range(99) < density, r == h - 1 && c == w - 1);
        sprites_sent++;
    endtask

    initial begin
        int phase;
        int lw, lh, lx, ly, tw, th, tx, ty;
        int total;
        logic [3:0] diag;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = spc_pkg::OP_LOAD;
        s_pos_x     = '0;
        s_pos_y     = '0;
        s_width     = '0;
        s_height    = '0;
        s_opaque    = 1'b0;
        s_last      = 1'b0;
        s_gap_pct   = 22;
        m_stall_pct = 65;
        phase       = 0;
        diag        = 4'b1001;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // test sprite before any load: nothing stored, so no hit
        send_pixel(spc_pkg::OP_TEST, 0, 0, 1, 1, 1'b1, 1'b1);

        // 2x2 diagonal at the negative screen corner
        for (int i = 0; i < 4; i++)
            send_pixel(spc_pkg::OP_LOAD, -2048, -2048, 2, 2, diag[i], i == 3);
        send_pixel(spc_pkg::OP_TEST, -2047, -2048, 1, 1, 1'b1, 1'b1); // clear pixel: miss
        send_pixel(spc_pkg::OP_TEST, -2047, -2047, 1, 1, 1'b1, 1'b1); // opaque pixel: hit

        // zero size clamps up to 1; oversize clamps down, last on the first pixel
        send_pixel(spc_pkg::OP_LOAD, 2047, 2047, 0, 0, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 2047, 2047, 63, 63, 1'b1, 1'b1);

        // 1x2 load with no last mark: counters wrap, the third pixel restarts and
        // clears the mask, the fourth ends it
        send_pixel(spc_pkg::OP_LOAD, 5, 5, 1, 2, 1'b1, 1'b0);
        send_pixel(spc_pkg::OP_LOAD, 5, 5, 1, 2, 1'b1, 1'b0);
        send_pixel(spc_pkg::OP_LOAD, 5, 5, 1, 2, 1'b0, 1'b0);
        send_pixel(spc_pkg::OP_LOAD, 5, 5, 1, 2, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 5, 5, 1, 1, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 5, 6, 1, 1, 1'b1, 1'b1);

        // op switches mid-sprite; counters are shared across ops
        send_pixel(spc_pkg::OP_LOAD, 100, -100, 2, 1, 1'b1, 1'b0);
        send_pixel(spc_pkg::OP_TEST, 99, -100, 2, 1, 1'b1, 1'b0);
        send_pixel(spc_pkg::OP_TEST, 100, -100, 2, 1, 1'b0, 1'b1);

        // 3x3 load cut short by last on its second pixel
        send_pixel(spc_pkg::OP_LOAD, 0, 0, 3, 3, 1'b1, 1'b0);
        send_pixel(spc_pkg::OP_LOAD, 0, 0, 3, 3, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 1, 0, 1, 1, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 2, 0, 1, 1, 1'b1, 1'b1);
        send_pixel(spc_pkg::OP_TEST, 0, 0, 1, 1, 1'b0, 1'b1); // clear test pixel on opaque
        wait_for_results();

        // ---- random part ----
        total = beats_sent + RANDOM_BEATS;
        while (beats_sent < total) begin
            // three idle regimes, each entered with the pipe drained
            if (phase == 0 && beats_sent >= total / 3) begin
                phase = 1;
                wait_for_results();
                s_gap_pct   = 65;
                m_stall_pct = 22;
            end else if (phase == 1 && beats_sent >= 2 * total / 3) begin
                phase = 2;
                wait_for_results();
                s_gap_pct   = 0;
                m_stall_pct = 0;
            end

            if ($urandom_range(99) < 15) begin
                // noise: any op, any size encoding, last at random
                repeat ($urandom_range(6, 1)) begin
                    send_pixel(spc_pkg::op_t'($urandom_range(1)),
                               spc_pkg::POS_W'($urandom), spc_pkg::POS_W'($urandom),
                               spc_pkg::SIZE_W'($urandom_range(63)),
                               spc_pkg::SIZE_W'($urandom_range(63)),
                               1'($urandom_range(1)), $urandom_range(9) < 3);
                    noise_beats++;
                end
            end else begin
                lw = pick_side();
                lh = (lw == MAX_SIDE) ? $urandom_range(2, 1) : pick_side();
                if (lh == MAX_SIDE && lw > 2) lw = $urandom_range(2, 1);
                lx = pick_pos();
                ly = pick_pos();
                send_sprite(spc_pkg::OP_LOAD, lx, ly, lw, lh, $urandom_range(100));
                repeat ($urandom_range(3, 1)) begin
                    tw = pick_side();
                    th = (tw == MAX_SIDE) ? $urandom_range(2, 1) : pick_side();
                    if (th == MAX_SIDE && tw > 2) tw = $urandom_range(2, 1);
                    if ($urandom_range(4) != 0) begin
                        // placed so the two boxes overlap or just touch
                        tx = lx + int'($urandom_range(lw + tw)) - tw;
                        ty = ly + int'($urandom_range(lh + th)) - th;
                    end else begin
                        tx = pick_pos();
                        ty = pick_pos();
                    end
                    send_sprite(spc_pkg::OP_TEST, tx, ty, tw, th, $urandom_range(100));
                end
            end

            if ($urandom_range(29) == 0) wait_for_results();
        end

        // ---- drain and verdict ----
        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run covered %0d pixel beats: %0d whole sprites and %0d noise beats",
                 beats_sent, sprites_sent, noise_beats);
        $display("Checked %0d collision beats (%0d hits) over three idle regimes",
                 results_seen, hits_seen);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_queue.sv
rtl/spc_front.sv
rtl/spc_back.sv
rtl/sprite_pixel_collision.sv
rtl/spc_checker.sv
verif/sprite_pixel_collision_checker.sv
verif/tb_sprite_pixel_collision.sv
